@@ sv/rwc_pkg.sv @@
// Package for the rolling weak checksum block.
// Holds the shared constants and the queue entry type; no dependencies.
package rwc_pkg;

  localparam int WindowMaxDefault = 1024;
  localparam int CfgWidth         = 11;
  localparam int CfgResetLen      = 1024;
  localparam int QueueDepth       = 2;

  // One classified item on its way from the front end to the sum engine.
  typedef struct packed {
    logic [7:0]  data_byte;  // new byte entering the window
    logic [7:0]  old_byte;   // byte leaving the window, zero while filling
    logic [15:0] old_prod;   // window length times the leaving byte, mod 2^16
    logic        start;      // clear both sums before this byte
    logic        produce;    // this item yields a checksum
  } rwc_entry_t;

endpackage

@@ sv/rwc_if.sv @@
// Handshake channels of the rolling weak checksum block.
// Depends on nothing but the payload widths of the byte and checksum items.
interface rwc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_req;

  modport source (output valid, output data_byte, output start_req, input ready);
  modport sink   (input valid, input data_byte, input start_req, output ready);
endinterface

interface rwc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] checksum;

  modport source (output valid, output checksum, input ready);
  modport sink   (input valid, input checksum, output ready);
endinterface

@@ sv/rwc_front.sv @@
// Front end: accepts bytes, tracks fill count and write pointer, keeps the
// byte history memory and hands classified items to the queue. Uses rwc_pkg.
module rwc_front
  import rwc_pkg::*;
#(
  parameter int WINDOW_MAX = WindowMaxDefault,
  localparam int AW = $clog2(WINDOW_MAX),
  localparam int CW = $clog2(WINDOW_MAX + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  rwc_in_if.sink        in_chan,
  input  logic [CW-1:0] win_len,
  output logic          push_valid,
  output rwc_entry_t    push_entry,
  input  logic          push_ok
);

  localparam logic [CW:0]   WmaxExt  = (CW + 1)'(WINDOW_MAX);
  localparam logic [AW-1:0] WrapLast = AW'(WINDOW_MAX - 1);

  logic [7:0]    hist_mem [WINDOW_MAX];
  logic [7:0]    rdata_r;

  logic [CW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic          st_valid_r;
  logic [7:0]    st_byte_r;
  logic          st_start_r;
  logic          st_roll_r;
  logic          st_produce_r;

  logic [CW-1:0] fc;
  logic [AW-1:0] wp;
  logic [CW:0]   wp_ext;
  logic [CW:0]   len_ext;
  logic [CW:0]   rd_ext;
  logic [AW-1:0] rd_addr;
  logic          roll;
  logic          produce;
  logic          accept;
  logic [15:0]   prod;

  always_comb begin
    fc       = in_chan.start_req ? '0 : fill_r;
    wp       = in_chan.start_req ? '0 : wptr_r;
    roll     = (fc >= win_len);
    produce  = roll || ((fc + CW'(1)) == win_len);
    fill_nxt = roll ? fc : (fc + CW'(1));
    wptr_nxt = (wp == WrapLast) ? '0 : (wp + AW'(1));
    wp_ext   = (CW + 1)'(wp);
    len_ext  = (CW + 1)'(win_len);
    if (wp_ext >= len_ext) begin
      rd_ext = wp_ext - len_ext;
    end else begin
      rd_ext = wp_ext + WmaxExt - len_ext;
    end
    rd_addr = rd_ext[AW-1:0];
  end

  assign in_chan.ready = !st_valid_r || push_ok;
  assign accept        = in_chan.valid && in_chan.ready;

  // History memory: the read returns the old contents when it hits the
  // address written in the same cycle, which a full-size window relies on.
  always_ff @(posedge clk) begin
    if (accept) begin
      rdata_r       <= hist_mem[rd_addr];
      hist_mem[wp]  <= in_chan.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
      fill_r     <= '0;
      wptr_r     <= '0;
    end else if (accept) begin
      st_valid_r <= 1'b1;
      fill_r     <= fill_nxt;
      wptr_r     <= wptr_nxt;
    end else if (push_ok) begin
      st_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_byte_r    <= in_chan.data_byte;
      st_start_r   <= in_chan.start_req;
      st_roll_r    <= roll;
      st_produce_r <= produce;
    end
  end

  // Length times the leaving byte; only the low 16 bits matter for s2.
  assign prod = 16'(win_len) * {8'd0, rdata_r};

  always_comb begin
    push_valid          = st_valid_r;
    push_entry.data_byte = st_byte_r;
    push_entry.old_byte  = st_roll_r ? rdata_r : 8'd0;
    push_entry.old_prod  = st_roll_r ? prod : 16'd0;
    push_entry.start     = st_start_r;
    push_entry.produce   = st_produce_r;
  end

endmodule

@@ sv/rwc_queue.sv @@
// Two-entry queue between the front end and the sum engine.
// Uses the entry type from rwc_pkg.
module rwc_queue
  import rwc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  input  rwc_entry_t push_entry,
  output logic       push_ok,
  output logic       pop_valid,
  output rwc_entry_t pop_entry,
  input  logic       pop_req
);

  localparam int PW = $clog2(QueueDepth);
  localparam int NW = $clog2(QueueDepth + 1);

  rwc_entry_t    entries_r [QueueDepth];
  logic [PW-1:0] wptr_r;
  logic [PW-1:0] rptr_r;
  logic [NW-1:0] count_r;
  logic          do_push;
  logic          do_pop;

  assign pop_valid = (count_r != '0);
  assign pop_entry = entries_r[rptr_r];
  assign do_pop    = pop_valid && pop_req;
  assign push_ok   = (count_r != NW'(QueueDepth)) || do_pop;
  assign do_push   = push_valid && push_ok;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == PW'(QueueDepth - 1)) ? '0 : (wptr_r + PW'(1));
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == PW'(QueueDepth - 1)) ? '0 : (rptr_r + PW'(1));
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + NW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - NW'(1);
      end
    end
  end

endmodule

@@ sv/rwc_back.sv @@
// Sum engine: updates s1 and s2 for each queued item and holds the result
// in the output register. Uses rwc_pkg and the output channel interface.
module rwc_back
  import rwc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       pop_valid,
  input  rwc_entry_t pop_entry,
  output logic       pop_req,
  rwc_out_if.source  out_chan
);

  logic [15:0] s1_r, s1_nxt;
  logic [15:0] s2_r, s2_nxt;
  logic        out_valid_r;
  logic [31:0] out_sum_r;
  logic [15:0] base1, base2;
  logic        take;

  // Filling items carry a zero leaving byte and product, so one update
  // serves both filling and rolling.
  always_comb begin
    base1  = pop_entry.start ? 16'd0 : s1_r;
    base2  = pop_entry.start ? 16'd0 : s2_r;
    s1_nxt = base1 - 16'(pop_entry.old_byte) + 16'(pop_entry.data_byte);
    s2_nxt = base2 - pop_entry.old_prod + s1_nxt;
  end

  assign pop_req = !pop_entry.produce || !out_valid_r || out_chan.ready;
  assign take    = pop_valid && pop_req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r        <= '0;
      s2_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        s1_r <= s1_nxt;
        s2_r <= s2_nxt;
      end
      if (take && pop_entry.produce) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && pop_entry.produce) begin
      out_sum_r <= {s2_nxt, s1_nxt};
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.checksum = out_sum_r;

endmodule

@@ sv/rolling_window_weak_checksum.sv @@
// Rolling weak checksum over a byte stream, one byte per cycle sustained
// while the output is not stalled. A result goes from the front-end stage
// through the queue to the output register; the s1/s2 update sets the rate.
// Reset (rst_n low at a clock edge) clears the sums, fill count, write
// pointer and queue and sets the window length to its default; the history
// memory is not cleared, since only bytes written after a start are read.
module rolling_window_weak_checksum
  import rwc_pkg::*;
#(
  parameter int WINDOW_MAX = WindowMaxDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  rwc_in_if.sink              in_chan,
  rwc_out_if.source           out_chan,
  input  logic                cfg_we,
  input  logic [CfgWidth-1:0] cfg_wdata
);

  // Counts up to and including WINDOW_MAX need this many bits.
  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int RstLen = (CfgResetLen > WINDOW_MAX) ? WINDOW_MAX : CfgResetLen;

  // The window length is kept already clamped: zero acts as one and any
  // value beyond the history depth acts as the full depth.
  logic [CW-1:0] win_len_r, win_len_nxt;
  logic [31:0]   len_clamp;

  always_comb begin
    if (cfg_wdata == '0) begin
      len_clamp = 32'd1;
    end else if (32'(cfg_wdata) > 32'(WINDOW_MAX)) begin
      len_clamp = 32'(WINDOW_MAX);
    end else begin
      len_clamp = 32'(cfg_wdata);
    end
    win_len_nxt = len_clamp[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r <= CW'(RstLen);
    end else if (cfg_we) begin
      win_len_r <= win_len_nxt;
    end
  end

  // Front end to queue, and queue to sum engine.
  logic       push_valid;
  rwc_entry_t push_entry;
  logic       push_ok;
  logic       pop_valid;
  rwc_entry_t pop_entry;
  logic       pop_req;

  // The front end classifies each item as filling or rolling and fetches
  // the byte that leaves the window from the history memory.
  rwc_front #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .win_len    (win_len_r),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ok    (push_ok)
  );

  // A short queue lets the front end keep taking items while a result
  // waits in the output register.
  rwc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ok    (push_ok),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .pop_req    (pop_req)
  );

  // The sum engine applies each item to s1 and s2 in order and registers
  // the packed checksum for every full window.
  rwc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_entry (pop_entry),
    .pop_req   (pop_req),
    .out_chan  (out_chan)
  );

endmodule

@@ sv/rwc_checker.sv @@
// Port-level checks for the rolling weak checksum block, bound to the top.
// Sees only the top-level handshake and payload signals.
module rwc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_checksum
);

  // Reset leaves no result pending.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // The input side only stalls when a result is held up downstream.
  assert property (@(posedge clk) disable iff (!rst_n) !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

  assert property (@(posedge clk) disable iff (!rst_n)
                   out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk) disable iff (!rst_n)
                   out_valid && !out_ready |=> $stable(out_checksum))
    else $error("checksum changed while stalled");

endmodule

bind rolling_window_weak_checksum rwc_checker u_rwc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_checksum (out_chan.checksum)
);
